// File: rtl/fupd_pkg.sv
// ----------------------------------------------------------------------------
// fupd_pkg
// Shared types and character constants for the form-encoded text decoder.
// ----------------------------------------------------------------------------
package fupd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] count_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_PCT    = 2'd1,
    PH_DIGIT  = 2'd2,
    PH_DRAIN  = 2'd3
  } phase_e;

  // hex digit decode result
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  localparam byte_t  CHAR_NUL   = 8'h00;
  localparam byte_t  CHAR_PLUS  = 8'h2B;
  localparam byte_t  CHAR_PCT   = 8'h25;
  localparam byte_t  CHAR_AMP   = 8'h26;
  localparam byte_t  CHAR_SPACE = 8'h20;
  localparam count_t CAP_RESET  = 16'd256;

  function automatic hex_t hex_decode(input byte_t c);
    hex_t r;
    r.ok  = 1'b0;
    r.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.nib = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// File: rtl/fupd_in_if.sv
// ----------------------------------------------------------------------------
// fupd_in_if
// Encoded byte channel: valid/ready with one encoded character.
// ----------------------------------------------------------------------------
interface fupd_in_if;
  import fupd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: rtl/fupd_out_if.sv
// ----------------------------------------------------------------------------
// fupd_out_if
// Decoded result channel: valid/ready with byte, end flag and count.
// ----------------------------------------------------------------------------
interface fupd_out_if;
  import fupd_pkg::*;

  logic   valid;
  logic   ready;
  byte_t  out_byte;
  logic   ends;
  count_t decoded_count;

  modport source (output valid, output out_byte, output ends, output decoded_count,
                  input ready);
  modport sink   (input valid, input out_byte, input ends, input decoded_count,
                  output ready);
endinterface

// File: rtl/form_url_percent_decoder.sv
// ----------------------------------------------------------------------------
// form_url_percent_decoder
// Streaming form-encoded text decoder, one encoded byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : encoded characters, one per request; NUL ends a string.
//   out_o : one result per decoded byte (ends = 0) and one per string end
//           (ends = 1, out_byte = 0, decoded_count final). Escape bytes and
//           drained bytes give no result.
//   cfg_we_i / cfg_wdata_i : output capacity; write only while idle.
// Path: an accepted request sits in the input register, is decoded, and its
//   result loads the result register when that register can take it.
// Throughput: one request per cycle while out_o is not held, set by the
//   single decode step between the input register and the result register.
// Reset: capacity returns to 256, decode state to the normal phase with a
//   zero count; both registers empty.
// Stall: while out_o is held, the result register keeps its content, the
//   input register fills, then in_i.ready drops. Nothing is lost.
// ----------------------------------------------------------------------------
module form_url_percent_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  fupd_pkg::count_t cfg_wdata_i,
  fupd_in_if.sink          in_i,
  fupd_out_if.source       out_o
);
  import fupd_pkg::*;

  // configuration
  count_t cap_q;
  count_t limit;

  // input register
  logic  in_vld_q;
  byte_t in_byte_q;

  // decode state
  phase_e     phase_q, phase_d;
  logic [3:0] hn_q, hn_d;
  logic       hv_q, hv_d;
  count_t     count_q, count_d;

  // result register
  logic   out_vld_q;
  byte_t  out_byte_q;
  logic   out_end_q;
  count_t out_cnt_q;

  // step outputs
  logic   res_vld;
  byte_t  res_byte;
  logic   res_end;
  count_t res_cnt;

  logic   res_ready;   // result register can take a new value
  logic   step;        // input register content is decoded this cycle
  hex_t   hx;
  count_t count_inc;

  assign limit     = cap_q - 16'd1;
  assign res_ready = !out_vld_q || out_o.ready;
  assign step      = in_vld_q && res_ready;
  assign in_i.ready = !in_vld_q || res_ready;
  assign hx        = hex_decode(in_byte_q);
  assign count_inc = count_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  // decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      hn_q    <= 4'd0;
      hv_q    <= 1'b0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      hn_q    <= hn_d;
      hv_q    <= hv_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    hn_d     = hn_q;
    hv_d     = hv_q;
    count_d  = count_q;
    res_vld  = 1'b0;
    res_byte = CHAR_NUL;
    res_end  = 1'b0;
    res_cnt  = count_q;
    if (step) begin
      unique case (phase_q)
        PH_NORMAL: begin
          priority if (in_byte_q == CHAR_NUL) begin
            res_vld = 1'b1;
            res_end = 1'b1;
            count_d = '0;
            hn_d    = 4'd0;
            hv_d    = 1'b0;
          end else if (count_q >= limit || in_byte_q == CHAR_AMP) begin
            // end now, then drop bytes up to the NUL
            res_vld = 1'b1;
            res_end = 1'b1;
            count_d = '0;
            hn_d    = 4'd0;
            hv_d    = 1'b0;
            phase_d = PH_DRAIN;
          end else if (in_byte_q == CHAR_PLUS) begin
            res_vld  = 1'b1;
            res_byte = CHAR_SPACE;
            res_cnt  = count_inc;
            count_d  = count_inc;
          end else if (in_byte_q == CHAR_PCT) begin
            phase_d = PH_PCT;
          end else begin
            res_vld  = 1'b1;
            res_byte = in_byte_q;
            res_cnt  = count_inc;
            count_d  = count_inc;
          end
        end
        PH_PCT, PH_DIGIT: begin
          if (in_byte_q == CHAR_NUL) begin
            // NUL inside an escape ends the string
            res_vld = 1'b1;
            res_end = 1'b1;
            count_d = '0;
            hn_d    = 4'd0;
            hv_d    = 1'b0;
            phase_d = PH_NORMAL;
          end else if (phase_q == PH_PCT) begin
            hv_d    = hx.ok;
            hn_d    = hx.nib;
            phase_d = PH_DIGIT;
          end else begin
            hn_d    = 4'd0;
            hv_d    = 1'b0;
            phase_d = PH_NORMAL;
            if (hv_q && hx.ok) begin
              res_vld  = 1'b1;
              res_byte = {hn_q, hx.nib};
              res_cnt  = count_inc;
              count_d  = count_inc;
            end
          end
        end
        PH_DRAIN: begin
          if (in_byte_q == CHAR_NUL) begin
            phase_d = PH_NORMAL;
            count_d = '0;
          end
        end
        default: begin
          phase_d = PH_NORMAL;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_byte_q <= res_byte;
      out_end_q  <= res_end;
      out_cnt_q  <= res_cnt;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.ends          = out_end_q;
  assign out_o.decoded_count = out_cnt_q;

endmodule

// File: dv/fupd_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fupd_tb_pkg
// Decode tracker for the form-encoded text decoder bench: mirrors the decode
// state, queues the results each request should give and checks them.
// ----------------------------------------------------------------------------
package fupd_tb_pkg;
  import fupd_pkg::*;

  typedef struct {
    byte_t  data;
    logic   ends;
    count_t count;
  } decoded_t;

  class form_decode_tracker;
    count_t      capacity;
    phase_e      ph;
    logic [3:0]  hi_nib;
    logic        hi_ok;
    count_t      count;
    decoded_t    due_decodes[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned ends_seen;

    function new();
      capacity     = CAP_RESET;
      ph           = PH_NORMAL;
      hi_nib       = 4'h0;
      hi_ok        = 1'b0;
      count        = '0;
      mismatches   = 0;
      results_seen = 0;
      ends_seen    = 0;
    endfunction

    // classify one character as a hex digit, either case
    function hex_t digit_of(byte_t c);
      hex_t  d;
      byte_t lc;
      byte_t v;
      lc    = c | 8'h20;
      d.ok  = 1'b0;
      d.nib = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
        v     = c - 8'h30;
        d.ok  = 1'b1;
        d.nib = v[3:0];
      end else if (lc >= 8'h61 && lc <= 8'h66) begin
        v     = lc - 8'h57;
        d.ok  = 1'b1;
        d.nib = v[3:0];
      end
      return d;
    endfunction

    function void emit_char(byte_t b);
      decoded_t r;
      count  = count + 16'd1;
      r.data = b;
      r.ends = 1'b0;
      r.count = count;
      due_decodes.push_back(r);
    endfunction

    function void finish_string(phase_e nxt);
      decoded_t r;
      r.data  = CHAR_NUL;
      r.ends  = 1'b1;
      r.count = count;
      due_decodes.push_back(r);
      count  = '0;
      hi_nib = 4'h0;
      hi_ok  = 1'b0;
      ph     = nxt;
    endfunction

    // one accepted encoded byte
    function void note_request(byte_t c);
      count_t lim;
      hex_t   d;
      lim = capacity - 16'd1;
      d   = digit_of(c);
      case (ph)
        PH_NORMAL: begin
          if (c == CHAR_NUL) finish_string(PH_NORMAL);
          else if (count >= lim) finish_string(PH_DRAIN);
          else if (c == CHAR_PLUS) emit_char(CHAR_SPACE);
          else if (c == CHAR_AMP) finish_string(PH_DRAIN);
          else if (c == CHAR_PCT) ph = PH_PCT;
          else emit_char(c);
        end
        PH_PCT: begin
          if (c == CHAR_NUL) begin
            finish_string(PH_NORMAL);
          end else begin
            hi_ok  = d.ok;
            hi_nib = d.nib;
            ph     = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          if (c == CHAR_NUL) begin
            finish_string(PH_NORMAL);
          end else begin
            ph = PH_NORMAL;
            if (hi_ok && d.ok) emit_char({hi_nib, d.nib});
            hi_nib = 4'h0;
            hi_ok  = 1'b0;
          end
        end
        default: begin
          if (c == CHAR_NUL) begin
            ph    = PH_NORMAL;
            count = '0;
          end
        end
      endcase
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(byte_t b, logic e, count_t n);
      decoded_t want;
      results_seen++;
      if (e) ends_seen++;
      if (due_decodes.size() == 0) begin
        note_mismatch($sformatf("unexpected result byte %02h ends %0b count %0d", b, e, n));
        return;
      end
      want = due_decodes.pop_front();
      if (b !== want.data || e !== want.ends || n !== want.count)
        note_mismatch($sformatf(
          "result %0d: expected byte %02h ends %0b count %0d, got byte %02h ends %0b count %0d",
          results_seen, want.data, want.ends, want.count, b, e, n));
    endfunction

    function int unsigned pending();
      return due_decodes.size();
    endfunction
  endclass

endpackage

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Bench for the form-encoded text decoder: directed escapes and ends, then
// random form fields under a range of output capacities, with random gaps
// and back-pressure, every result checked against the decode tracker.
// ----------------------------------------------------------------------------
module testbench;
  import fupd_pkg::*;
  import fupd_tb_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 1000; // cycles without any request
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_CHARS  = 140;  // encoded bytes per phase
  localparam int unsigned SETTLE       = 4;    // decode latency plus margin

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we_i;
  count_t cfg_wdata_i;
  logic   no_idle;   // both sides run flat out while set

  fupd_in_if  in_if();
  fupd_out_if out_if();

  form_decode_tracker tracker;
  int unsigned        chars_sent;
  int unsigned        caps_written;

  form_url_percent_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Opening sequence at the reset capacity: empty string, plus, escapes in
  // both cases, a percent swallowing two ampersands, a bad escape, the byte
  // extremes, an ampersand end with draining, and NUL inside an escape after
  // the percent and after the first digit.
  byte_t opening [25] = '{
    CHAR_NUL,
    8'h41, CHAR_PLUS,
    CHAR_PCT, 8'h34, 8'h31,              // %41
    CHAR_PCT, 8'h66, 8'h46,              // %fF
    CHAR_PCT, CHAR_AMP, CHAR_AMP,        // ampersands eaten by the escape
    CHAR_PCT, 8'h47, 8'h30,              // %G0, dropped
    8'hFF, 8'h01,
    CHAR_AMP, 8'h7A, CHAR_NUL,           // end, drain 'z', NUL back to normal
    CHAR_PCT, CHAR_NUL,
    CHAR_PCT, 8'h37, CHAR_NUL
  };

  // ---------------------------------------------------------------- drivers
  // All driving happens at the falling edge; a task is entered and left at a
  // falling edge so valid is never touched twice in one step.
  task automatic send_char(input byte_t c);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= c;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_request(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every result has come back, then let any
  // request that gives no result clear the pipeline.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_capacity(input count_t cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.capacity = cap;
    caps_written++;
  endtask

  // ------------------------------------------------------------- generators
  function automatic byte_t plain_char();
    byte_t c;
    do begin
      if ($urandom_range(0, 1) == 0) c = byte_t'($urandom_range(8'h20, 8'h7E));
      else c = byte_t'($urandom_range(1, 255));
    end while (c == CHAR_PLUS || c == CHAR_PCT || c == CHAR_AMP);
    return c;
  endfunction

  function automatic byte_t any_non_nul();
    return byte_t'($urandom_range(1, 255));
  endfunction

  function automatic byte_t hex_char(input int unsigned nib);
    byte_t letter_a;
    letter_a = ($urandom_range(0, 1) == 0) ? 8'h61 : 8'h41;
    if (nib < 10) return byte_t'(8'h30 + nib);
    return byte_t'(letter_a + nib - 10);
  endfunction

  // One form field: a run of plain bytes, pluses and escapes (good, bad and
  // with an ampersand inside), closed mostly by NUL, sometimes by an
  // ampersand with trailing junk, and now and then left open so the string
  // runs on into the next field.
  task automatic send_field(input int unsigned max_len);
    byte_t       field_q[$];
    int unsigned len;
    int unsigned pick;
    int unsigned i;
    len = $urandom_range(0, max_len);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        field_q.push_back(plain_char());
      end else if (pick < 65) begin
        field_q.push_back(CHAR_PLUS);
      end else if (pick < 80) begin
        field_q.push_back(CHAR_PCT);
        field_q.push_back(hex_char($urandom_range(0, 15)));
        field_q.push_back(hex_char($urandom_range(0, 15)));
      end else if (pick < 90) begin
        field_q.push_back(CHAR_PCT);
        field_q.push_back(any_non_nul());
        field_q.push_back(any_non_nul());
      end else if (pick < 94) begin
        field_q.push_back(CHAR_PCT);
        field_q.push_back(CHAR_AMP);
        field_q.push_back(any_non_nul());
      end else begin
        field_q.push_back(any_non_nul());
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      field_q.push_back(CHAR_NUL);
    end else if (pick < 94) begin
      field_q.push_back(CHAR_AMP);
      len = $urandom_range(0, 3);
      for (i = 0; i < len; i++) field_q.push_back(any_non_nul());
      field_q.push_back(CHAR_NUL);
    end
    foreach (field_q[k]) send_char(field_q[k]);
  endtask

  function automatic count_t capacity_plan(input int unsigned p);
    case (p)
      0:       return 16'd1;
      1:       return 16'd2;
      2:       return 16'd65535;
      3:       return 16'd3;
      4:       return CAP_RESET;
      5:       return count_t'($urandom_range(1, 12));
      6:       return 16'd1;
      7:       return count_t'($urandom_range(1, 65535));
      8:       return 16'd4;
      9:       return 16'd65535;
      10:      return count_t'($urandom_range(2, 20));
      default: return 16'd7;
    endcase
  endfunction

  // -------------------------------------------------------------- stimulus
  initial begin
    int unsigned p;
    int unsigned phase_start;
    int unsigned burst;
    tracker      = new();
    chars_sent   = 0;
    caps_written = 0;
    no_idle      = 1'b0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part runs at the reset capacity
    foreach (opening[k]) send_char(opening[k]);

    // Random phases. Each capacity write waits until all results are back,
    // which also gives the sender its full pause. The string in progress is
    // not reset by a write, so a smaller capacity can land mid-string.
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      write_capacity(capacity_plan(p));
      no_idle     = (p % 4 == 2);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        if ($urandom_range(0, 9) == 0) begin
          // raw noise, NUL included
          burst = $urandom_range(1, 4);
          repeat (burst) send_char(byte_t'($urandom_range(0, 255)));
        end else begin
          send_field(($urandom_range(0, 9) == 0) ? 40 : 8);
        end
      end
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (8) @(negedge clk_i);
    $display("Summary: %0d encoded bytes over %0d capacity settings (1 to 65535).",
             chars_sent, caps_written);
    $display("Summary: %0d results checked, %0d of them string ends, %0d mismatches.",
             tracker.results_seen, tracker.ends_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------- receiver
  // Draws a stall per result; ready is high while waiting for one.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      tracker.check_result(out_if.out_byte, out_if.ends, out_if.decoded_count);
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------- watchdog
  // Any request moving on either side restarts the count.
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no request moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, tracker.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
